>>> rtl/core/pptrb_pkg.sv
// shared types and constants of the ping-pong tile reorder buffer
`timescale 1ns / 1ps

package pptrb_pkg;

    localparam int REG_W     = 9;
    localparam int ITER_W    = 17;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int OUT_W     = 64;

    localparam logic [REG_W-1:0] REG_RESET = 9'd1;

    // register index taken from paddr[2]
    localparam logic REG_ROW_BLOCKS = 1'b0;
    localparam logic REG_OUT_BLOCKS = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic tile_end;
        logic run_end;
    } t_step_ctrl;

    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
        clamp_reg = v[REG_W-1] ? 9'd256 : v;
    endfunction

endpackage

>>> rtl/core/pptrb_mem.sv
// dual-half tile buffer: one write port, one registered read port
`timescale 1ns / 1ps

module pptrb_mem #(
    parameter int WORD_BITS = 64,
    parameter int DEPTH     = 1024,
    parameter int AW        = 10
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/pptrb_seq.sv
// step and iteration counters with write and read address generation
`timescale 1ns / 1ps

module pptrb_seq #(
    parameter int ROW_BLOCK = 2,
    parameter int ROWS      = 4,
    parameter int COL_BLOCK = 2,
    parameter int COLS      = 4,
    parameter int OUT_BLOCK = 8,
    parameter int MEM_AW    = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [pptrb_pkg::REG_W-1:0]    i_row_blocks,
    input  logic [pptrb_pkg::REG_W-1:0]    i_out_blocks,
    output pptrb_pkg::t_step_ctrl          o_ctrl,
    output logic [MEM_AW-1:0]              o_waddr,
    output logic [MEM_AW-1:0]              o_raddr
);

    localparam int TILE_WORDS = ROW_BLOCK * ROWS * COL_BLOCK * COLS * OUT_BLOCK;
    localparam int TILE_AW = (TILE_WORDS > 1) ? $clog2(TILE_WORDS) : 1;
    localparam int C_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CB_W  = (COL_BLOCK > 1) ? $clog2(COL_BLOCK) : 1;
    localparam int R_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int OB_W  = (OUT_BLOCK > 1) ? $clog2(OUT_BLOCK) : 1;
    localparam int RB_W  = (ROW_BLOCK > 1) ? $clog2(ROW_BLOCK) : 1;
    localparam int S_C   = OUT_BLOCK;
    localparam int S_CB  = COLS * OUT_BLOCK;
    localparam int S_R   = COL_BLOCK * COLS * OUT_BLOCK;
    localparam int S_RB  = ROWS * COL_BLOCK * COLS * OUT_BLOCK;

    logic [C_W-1:0]   r_c;
    logic [CB_W-1:0]  r_cb;
    logic [R_W-1:0]   r_w_r;
    logic [OB_W-1:0]  r_w_ob;
    logic [RB_W-1:0]  r_w_rb;
    logic [OB_W-1:0]  r_r_ob;
    logic [R_W-1:0]   r_r_r;
    logic [RB_W-1:0]  r_r_rb;
    logic [pptrb_pkg::ITER_W-1:0] r_iter;

    logic [pptrb_pkg::ITER_W-1:0] tiles;
    logic c_top, cb_top, w_r_top, w_ob_top, w_rb_top, r_ob_top, r_r_top;
    logic last_step, last_iter;
    logic [TILE_AW-1:0] w_in_tile, r_in_tile;

    assign tiles = pptrb_pkg::ITER_W'(pptrb_pkg::clamp_reg(i_row_blocks))
                 * pptrb_pkg::ITER_W'(pptrb_pkg::clamp_reg(i_out_blocks));

    assign c_top    = (r_c    == C_W'(COLS - 1));
    assign cb_top   = (r_cb   == CB_W'(COL_BLOCK - 1));
    assign w_r_top  = (r_w_r  == R_W'(ROWS - 1));
    assign w_ob_top = (r_w_ob == OB_W'(OUT_BLOCK - 1));
    assign w_rb_top = (r_w_rb == RB_W'(ROW_BLOCK - 1));
    assign r_ob_top = (r_r_ob == OB_W'(OUT_BLOCK - 1));
    assign r_r_top  = (r_r_r  == R_W'(ROWS - 1));

    assign last_step = c_top && cb_top && w_r_top && w_ob_top && w_rb_top;
    assign last_iter = (r_iter >= tiles);

    assign o_ctrl.wr_en    = (r_iter < tiles);
    assign o_ctrl.rd_en    = (r_iter != '0);
    assign o_ctrl.tile_end = last_step;
    assign o_ctrl.run_end  = last_step && last_iter;

    assign w_in_tile = TILE_AW'(TILE_AW'(r_w_rb) * TILE_AW'(S_RB)
                     + TILE_AW'(r_w_r) * TILE_AW'(S_R)
                     + TILE_AW'(r_cb) * TILE_AW'(S_CB)
                     + TILE_AW'(r_c) * TILE_AW'(S_C)
                     + TILE_AW'(r_w_ob));
    assign r_in_tile = TILE_AW'(TILE_AW'(r_r_rb) * TILE_AW'(S_RB)
                     + TILE_AW'(r_r_r) * TILE_AW'(S_R)
                     + TILE_AW'(r_cb) * TILE_AW'(S_CB)
                     + TILE_AW'(r_c) * TILE_AW'(S_C)
                     + TILE_AW'(r_r_ob));

    // write half is iteration bit 0, read half is the other one
    assign o_waddr = MEM_AW'(w_in_tile) + (r_iter[0] ? MEM_AW'(TILE_WORDS) : '0);
    assign o_raddr = MEM_AW'(r_in_tile) + (r_iter[0] ? '0 : MEM_AW'(TILE_WORDS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c    <= '0;
            r_cb   <= '0;
            r_w_r  <= '0;
            r_w_ob <= '0;
            r_w_rb <= '0;
            r_r_ob <= '0;
            r_r_r  <= '0;
            r_r_rb <= '0;
            r_iter <= '0;
        end else if (i_accept) begin
            r_c <= c_top ? '0 : r_c + 1'b1;
            if (c_top) begin
                r_cb <= cb_top ? '0 : r_cb + 1'b1;
            end
            // write order: row, then out-block, then row-block
            if (c_top && cb_top) begin
                r_w_r <= w_r_top ? '0 : r_w_r + 1'b1;
                if (w_r_top) begin
                    r_w_ob <= w_ob_top ? '0 : r_w_ob + 1'b1;
                    if (w_ob_top) begin
                        r_w_rb <= w_rb_top ? '0 : r_w_rb + 1'b1;
                    end
                end
            end
            // read order: out-block, then row, then row-block
            if (c_top && cb_top) begin
                r_r_ob <= r_ob_top ? '0 : r_r_ob + 1'b1;
                if (r_ob_top) begin
                    r_r_r <= r_r_top ? '0 : r_r_r + 1'b1;
                    if (r_r_top) begin
                        r_r_rb <= last_step ? '0 : r_r_rb + 1'b1;
                    end
                end
            end
            if (last_step) begin
                r_iter <= last_iter ? '0 : r_iter + 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/ping_pong_tile_reorder_buffer_top.sv
// top level of the ping-pong tile reorder buffer
//
// channel  direction  handshake                   payload
// in       sink       i_in_valid / o_in_ready     i_data_word
// out      source     o_out_valid / i_out_ready   o_out_word, o_tile_end, o_run_end
// cfg      apb slave  psel, penable, pwrite       paddr, pwdata, prdata
//
// one item per cycle while o_in_ready is high; a result passes the memory read register, then the output register
// a run is row_blocks*out_blocks+1 tiles; the first tile gives no results
// reset is synchronous, active low; buffer contents are not cleared
// input ready drops only while the read stage holds an item that cannot move to the output
`timescale 1ns / 1ps

module ping_pong_tile_reorder_buffer_top #(
    parameter int ROW_BLOCK = 2,
    parameter int ROWS      = 4,
    parameter int COL_BLOCK = 2,
    parameter int COLS      = 4,
    parameter int OUT_BLOCK = 8,
    parameter int WORD_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [63:0]                       i_data_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [63:0]                       o_out_word,
    output logic                              o_tile_end,
    output logic                              o_run_end,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pptrb_pkg::PADDR_W-1:0]     paddr,
    input  logic [pptrb_pkg::PDATA_W-1:0]     pwdata,
    output logic [pptrb_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int TILE_WORDS = ROW_BLOCK * ROWS * COL_BLOCK * COLS * OUT_BLOCK;
    localparam int DEPTH      = 2 * TILE_WORDS;
    localparam int MEM_AW     = $clog2(DEPTH);

    logic [pptrb_pkg::REG_W-1:0] r_row_blocks;
    logic [pptrb_pkg::REG_W-1:0] r_out_blocks;
    logic                        cfg_wr;

    pptrb_pkg::t_step_ctrl ctrl;
    logic [MEM_AW-1:0]     waddr, raddr;
    logic [WORD_BITS-1:0]  rd_data;
    logic                  accept;
    logic                  s1_move;

    logic                 r_s1_valid, n_s1_valid;
    logic                 r_s1_tile_end;
    logic                 r_s1_run_end;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    logic                 r_out_tile_end;
    logic                 r_out_run_end;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_blocks <= pptrb_pkg::REG_RESET;
            r_out_blocks <= pptrb_pkg::REG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == pptrb_pkg::REG_ROW_BLOCKS) begin
                r_row_blocks <= pwdata[pptrb_pkg::REG_W-1:0];
            end else begin
                r_out_blocks <= pwdata[pptrb_pkg::REG_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            pptrb_pkg::REG_ROW_BLOCKS: prdata = pptrb_pkg::PDATA_W'(r_row_blocks);
            pptrb_pkg::REG_OUT_BLOCKS: prdata = pptrb_pkg::PDATA_W'(r_out_blocks);
            default:                   prdata = '0;
        endcase
    end

    // handshake
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign n_s1_valid = (accept && ctrl.rd_en) || (r_s1_valid && !s1_move);

    pptrb_seq #(
        .ROW_BLOCK (ROW_BLOCK),
        .ROWS      (ROWS),
        .COL_BLOCK (COL_BLOCK),
        .COLS      (COLS),
        .OUT_BLOCK (OUT_BLOCK),
        .MEM_AW    (MEM_AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_row_blocks (r_row_blocks),
        .i_out_blocks (r_out_blocks),
        .o_ctrl       (ctrl),
        .o_waddr      (waddr),
        .o_raddr      (raddr)
    );

    pptrb_mem #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (DEPTH),
        .AW        (MEM_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && ctrl.wr_en),
        .i_waddr   (waddr),
        .i_wdata   (i_data_word[WORD_BITS-1:0]),
        .i_rd_en   (accept && ctrl.rd_en),
        .i_raddr   (raddr),
        .o_rd_data (rd_data)
    );

    // read stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ctrl.rd_en) begin
            r_s1_tile_end <= ctrl.tile_end;
            r_s1_run_end  <= ctrl.run_end;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_word     <= rd_data;
            r_out_tile_end <= r_s1_tile_end;
            r_out_run_end  <= r_s1_run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = 64'(r_out_word);
    assign o_tile_end  = r_out_tile_end;
    assign o_run_end   = r_out_run_end;

    a_run_end_on_tile_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_end) |-> o_tile_end)
        else $error("run end without tile end");

    a_read_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctrl.rd_en) |=> r_s1_valid)
        else $error("read item lost before read stage");

    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("read stage did not move to output");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.run_end) |-> !ctrl.wr_en)
        else $error("write during final tile");

endmodule
